/* rtl/core/pcoc_pkg.sv */
// Package for the phase current offset calibration unit.
// Holds the register map, the fixed field widths and the item codes.
// Depends on nothing; the top level uses it.
`default_nettype none

package pcoc_pkg;

   localparam int GAIN_W      = 17;
   localparam int SETTLE_W    = 24;
   localparam int LIMIT_W     = 15;
   localparam int COUNT_W     = 24;
   localparam int GAIN_SHIFT  = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int REG_INDEX_W = 2;

   localparam logic [GAIN_W-1:0]   GAIN_ONE     = GAIN_W'(1 << GAIN_SHIFT);
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
   localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(12000);

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_FILTER_GAIN    = 2'd0,
      REG_SETTLE_SAMPLES = 2'd1,
      REG_MAX_OFFSET     = 2'd2
   } reg_index_type;

   localparam logic ITEM_CALIBRATE = 1'b0;
   localparam logic ITEM_MEASURE   = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/pcoc_if.sv */
// Channel interfaces of the phase current offset calibration unit.
// pcoc_req_if carries raw sample words, pcoc_rsp_if carries corrected words.
// Depends on nothing but the sample width parameter.
`default_nettype none

interface pcoc_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [SAMPLE_BITS-1:0] phase_a_raw;
   logic signed [SAMPLE_BITS-1:0] phase_b_raw;
   logic signed [SAMPLE_BITS-1:0] phase_c_raw;

   modport source (output valid, req_type, phase_a_raw, phase_b_raw, phase_c_raw,
                   input ready);
   modport sink   (input valid, req_type, phase_a_raw, phase_b_raw, phase_c_raw,
                   output ready);
endinterface

interface pcoc_rsp_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] phase_a_corrected;
   logic signed [SAMPLE_BITS-1:0] phase_b_corrected;
   logic signed [SAMPLE_BITS-1:0] phase_c_corrected;
   logic                          offsets_valid;

   modport source (output valid, phase_a_corrected, phase_b_corrected,
                   phase_c_corrected, offsets_valid, input ready);
   modport sink   (input valid, phase_a_corrected, phase_b_corrected,
                   phase_c_corrected, offsets_valid, output ready);
endinterface

`default_nettype wire

/* rtl/core/phase_current_offset_calibration_unit.sv */
// Top level of the phase current offset calibration unit.
// Uses pcoc_pkg for constants and the channel interfaces from pcoc_if.sv.
//
// Usage: each request word holds three signed phase current samples and a
// type bit. A calibration word moves each phase offset towards its sample by
// a first-order low-pass step and advances a saturating sample counter; it
// yields no response word. A measurement word yields one response word with
// the offset-corrected currents, or zeros with offsets_valid low when the
// counter has not reached settle_samples or any offset is not below
// max_offset.
// A request word is taken into the input register, then the filter, rounding
// and saturation logic fills the output register. One word is accepted every
// cycle unless a measurement word waits in the input register for a stalled
// output; the offset update is registered, and the next word reads its result.
// When the receiver stalls, the response word holds in the output register
// while a calibration word behind it still proceeds; a measurement word waits
// in the input register and backpressure then reaches the request side.
// Reset clears the offsets, the counter, all valid flags and the registers to
// their reset values. The user must write registers through the APB-style port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module phase_current_offset_calibration_unit #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pcoc_req_if.sink                               req_chan,
   pcoc_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pcoc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pcoc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [pcoc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   localparam int S      = SAMPLE_BITS;
   localparam int F      = FRAC_BITS;
   localparam int OW     = S + F;
   localparam int DW     = S + F + 1;
   localparam int PW     = DW + pcoc_pkg::GAIN_W + 1;
   localparam int RW     = S + 2;
   localparam int MW     = ((S > pcoc_pkg::LIMIT_W) ? S : pcoc_pkg::LIMIT_W) + F + 1;
   localparam int LANES  = 3;

   // Configuration registers.
   logic [pcoc_pkg::GAIN_W-1:0]   gain_ff;
   logic [pcoc_pkg::SETTLE_W-1:0] settle_ff;
   logic [pcoc_pkg::LIMIT_W-1:0]  limit_ff;
   logic                          csr_write;
   pcoc_pkg::reg_index_type       csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = pcoc_pkg::reg_index_type'(csr_paddr[pcoc_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= '0;
         settle_ff <= pcoc_pkg::SETTLE_RESET;
         limit_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            pcoc_pkg::REG_FILTER_GAIN: begin
               gain_ff <= csr_pwdata[pcoc_pkg::GAIN_W-1:0];
            end
            pcoc_pkg::REG_SETTLE_SAMPLES: begin
               settle_ff <= csr_pwdata[pcoc_pkg::SETTLE_W-1:0];
            end
            pcoc_pkg::REG_MAX_OFFSET: begin
               limit_ff <= csr_pwdata[pcoc_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pcoc_pkg::REG_FILTER_GAIN:
            csr_prdata = pcoc_pkg::CSR_DATA_W'(gain_ff);
         pcoc_pkg::REG_SETTLE_SAMPLES:
            csr_prdata = pcoc_pkg::CSR_DATA_W'(settle_ff);
         pcoc_pkg::REG_MAX_OFFSET:
            csr_prdata = pcoc_pkg::CSR_DATA_W'(limit_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic                  in_type_ff;
   logic signed [S-1:0]   in_raw_ff [LANES];
   logic                  in_advance;
   logic                  out_free;
   logic                  req_take;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   logic signed [S-1:0]   out_data_ff [LANES];
   logic                  out_ok_ff;

   // Calibration state.
   logic signed [OW-1:0]          offset_ff [LANES];
   logic signed [OW-1:0]          offset_in [LANES];
   logic [pcoc_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic [pcoc_pkg::GAIN_W-1:0]   gain_eff;
   logic signed [S-1:0]           corr     [LANES];
   logic                          in_limit [LANES];
   logic                          meas_ok;

   assign out_free    = !out_valid_ff || rsp_chan.ready;
   assign in_advance  = in_valid_ff && (in_type_ff == pcoc_pkg::ITEM_CALIBRATE || out_free);
   assign req_chan.ready = !in_valid_ff || in_advance;
   assign req_take    = req_chan.valid && req_chan.ready;
   assign in_valid_in = req_take || (in_valid_ff && !in_advance);

   assign gain_eff = (gain_ff > pcoc_pkg::GAIN_ONE) ? pcoc_pkg::GAIN_ONE : gain_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff   <= req_chan.req_type;
         in_raw_ff[0] <= req_chan.phase_a_raw;
         in_raw_ff[1] <= req_chan.phase_b_raw;
         in_raw_ff[2] <= req_chan.phase_c_raw;
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic signed [DW-1:0]   diff;
      logic signed [PW-1:0]   prod;
      logic signed [PW-1:0]   step;
      logic signed [PW-1:0]   sum;
      logic signed [DW:0]     biased;
      logic signed [RW-1:0]   rounded;
      logic        [MW-1:0]   mag;
      logic        [MW-1:0]   lim;

      assign diff = $signed({in_raw_ff[i][S-1], in_raw_ff[i], {F{1'b0}}})
                  - $signed({offset_ff[i][OW-1], offset_ff[i]});
      assign prod = PW'(diff) * PW'($signed({1'b0, gain_eff}));
      assign step = prod >>> pcoc_pkg::GAIN_SHIFT;
      assign sum  = PW'(offset_ff[i]) + step;
      assign offset_in[i] = sum[OW-1:0];

      assign biased  = $signed({diff[DW-1], diff}) + $signed((DW+1)'(1) <<< (F - 1));
      assign rounded = RW'(biased >>> F);
      always_comb begin
         if (rounded[RW-1:S-1] == '0 || rounded[RW-1:S-1] == '1) begin
            corr[i] = rounded[S-1:0];
         end else if (rounded[RW-1]) begin
            corr[i] = {1'b1, {(S-1){1'b0}}};
         end else begin
            corr[i] = {1'b0, {(S-1){1'b1}}};
         end
      end

      assign mag = offset_ff[i][OW-1] ? MW'(-$signed({offset_ff[i][OW-1], offset_ff[i]}))
                                      : MW'(offset_ff[i]);
      assign lim = MW'({limit_ff, {F{1'b0}}});
      assign in_limit[i] = mag < lim;
   end

   assign meas_ok = (count_ff >= settle_ff) && in_limit[0] && in_limit[1] && in_limit[2];

   assign count_in = (count_ff == pcoc_pkg::COUNT_MAX) ? count_ff
                                                       : count_ff + pcoc_pkg::COUNT_W'(1);

   assign out_valid_in = (in_advance && in_type_ff == pcoc_pkg::ITEM_MEASURE)
                       || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < LANES; i++) begin
            offset_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_advance && in_type_ff == pcoc_pkg::ITEM_CALIBRATE) begin
            count_ff <= count_in;
            for (int i = 0; i < LANES; i++) begin
               offset_ff[i] <= offset_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && in_type_ff == pcoc_pkg::ITEM_MEASURE) begin
         out_ok_ff <= meas_ok;
         for (int i = 0; i < LANES; i++) begin
            out_data_ff[i] <= meas_ok ? corr[i] : '0;
         end
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.phase_a_corrected = out_data_ff[0];
   assign rsp_chan.phase_b_corrected = out_data_ff[1];
   assign rsp_chan.phase_c_corrected = out_data_ff[2];
   assign rsp_chan.offsets_valid     = out_ok_ff;

endmodule

`default_nettype wire

/* rtl/core/pcoc_checker.sv */
// Port-level checker for the phase current offset calibration unit.
// Depends on the top level's ports only; bound to it at the end of this file.
`default_nettype none

module pcoc_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [SAMPLE_BITS-1:0] rsp_a,
   input wire logic [SAMPLE_BITS-1:0] rsp_b,
   input wire logic [SAMPLE_BITS-1:0] rsp_c,
   input wire logic                   rsp_ok
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response word dropped while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_a) && $stable(rsp_b) && $stable(rsp_c)
                                  && $stable(rsp_ok))
      else $error("Response word changed while stalled.");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_a == '0 && rsp_b == '0 && rsp_c == '0)
      else $error("Invalid response word carries non-zero currents.");

endmodule

bind phase_current_offset_calibration_unit pcoc_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_pcoc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_a     (rsp_chan.phase_a_corrected),
   .rsp_b     (rsp_chan.phase_b_corrected),
   .rsp_c     (rsp_chan.phase_c_corrected),
   .rsp_ok    (rsp_chan.offsets_valid)
);

`default_nettype wire
